@@ design/rre_pkg.sv @@
`timescale 1ns / 1ps
package rre_pkg;

  localparam int W = 32;

  typedef logic signed [W-1:0] coord_t;

  typedef struct packed {
    coord_t pos_x;
    coord_t pos_y;
    coord_t vel_x;
    coord_t vel_y;
  } req_t;

  typedef struct packed {
    coord_t     hit_x;
    coord_t     hit_y;
    logic [1:0] exit_status;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_EXIT    = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_NO_EXIT = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_LEFT   = 2'd0,
    CFG_RIGHT  = 2'd1,
    CFG_BOTTOM = 2'd2,
    CFG_TOP    = 2'd3
  } cfg_idx_e;

  // One divider lane between steps: remainder, dividend low bits shifting
  // out while quotient bits shift in, and the divisor.
  typedef struct packed {
    logic         ok;
    logic         neg;
    logic [W-1:0] rem;
    logic [W-1:0] dq;
    logic [W-1:0] d;
  } div_t;

endpackage

@@ design/rre_div_lane.sv @@
`timescale 1ns / 1ps
module rre_div_lane (
  input  logic                clk_i,
  input  logic [rre_pkg::W-1:0] en_i,
  input  rre_pkg::div_t       init_i,
  output rre_pkg::div_t       res_o
);

  rre_pkg::div_t st_q [rre_pkg::W];
  rre_pkg::div_t st_d [rre_pkg::W];

  // One restoring step per stage; the remainder stays below the divisor when it starts below it.
  always_comb begin
    logic [rre_pkg::W:0] r2;
    rre_pkg::div_t       src;
    for (int k = 0; k < rre_pkg::W; k++) begin
      src = (k == 0) ? init_i : st_q[(k == 0) ? 0 : k-1];
      r2 = {src.rem, src.dq[rre_pkg::W-1]};
      st_d[k] = src;
      if (r2 >= {1'b0, src.d}) begin
        r2 = r2 - {1'b0, src.d};
        st_d[k].dq = {src.dq[rre_pkg::W-2:0], 1'b1};
      end else begin
        st_d[k].dq = {src.dq[rre_pkg::W-2:0], 1'b0};
      end
      st_d[k].rem = r2[rre_pkg::W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < rre_pkg::W; k++) begin
      if (en_i[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign res_o = st_q[rre_pkg::W-1];

endmodule

@@ design/ray_rectangle_exit_point.sv @@
`timescale 1ns / 1ps
// Exit point of a ray from an axis-aligned rectangle, signed Q16.16.
//
// Program the four bounds through the write port (cfg_we_i, cfg_idx_i,
// cfg_data_i) while no request is in flight. A request on the input channel
// carries a start point and a velocity; one response per request comes out
// on the output channel, in order, with the exit point and a status code.
//
// One request is taken every cycle while the output is not stalled: two
// lanes (one for the x border, one for the y border) each run a 32x32
// multiplier stage and a 32-stage restoring divider, one quotient bit per
// stage, followed by the add and bounds check.
//
// Each stage holds its request when the stage after it is full and stalled;
// empty stages keep filling, so requests are taken until the whole pipeline
// is full behind a stalled output. Reset clears all valid bits and sets the
// bounds to zero.
module ray_rectangle_exit_point (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rre_pkg::req_t       in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rre_pkg::rsp_t       out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [rre_pkg::W-1:0] cfg_data_i
);

  localparam int W    = rre_pkg::W;
  localparam int NSTG = W + 5;
  localparam int LAST = NSTG - 1;

  typedef struct packed {
    logic [W-1:0] px;
    logic [W-1:0] py;
    logic         in_box;
    logic         vx_pos;
    logic         vy_pos;
  } cmn_t;

  typedef struct packed {
    logic         ok;
    logic         neg;
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic [W-1:0] d;
  } prep_t;

  typedef struct packed {
    logic           ok;
    logic           neg;
    logic [2*W-1:0] prod;
    logic [W-1:0]   d;
  } mul_t;

  logic signed [W-1:0] left_q, right_q, bottom_q, top_q;
  logic [NSTG-1:0] valid_q, en;
  rre_pkg::req_t req_q;
  cmn_t  cmn_q [1:LAST-1];
  prep_t prx_q, pry_q, prx_d, pry_d;
  mul_t  mux_q, muy_q;
  rre_pkg::div_t dvx_q, dvy_q, dvx_d, dvy_d, resx, resy;
  cmn_t  cmn_d;
  rre_pkg::rsp_t rsp_q, rsp_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      right_q  <= '0;
      bottom_q <= '0;
      top_q    <= '0;
    end else if (cfg_we_i) begin
      case (rre_pkg::cfg_idx_e'(cfg_idx_i))
        rre_pkg::CFG_LEFT:   left_q   <= cfg_data_i;
        rre_pkg::CFG_RIGHT:  right_q  <= cfg_data_i;
        rre_pkg::CFG_BOTTOM: bottom_q <= cfg_data_i;
        rre_pkg::CFG_TOP:    top_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or the stage after it moves on.
  always_comb begin
    en[LAST] = !valid_q[LAST] || !out_stall_i;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= in_valid_i;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // Stage 1: inside test, border offsets and operand magnitudes.
  always_comb begin
    logic signed [W:0] offx, offy, bx, by;
    logic signed [W-1:0] px, py, vx, vy;
    px = req_q.pos_x;
    py = req_q.pos_y;
    vx = req_q.vel_x;
    vy = req_q.vel_y;
    bx = (vx > 0) ? (W+1)'(right_q) : (W+1)'(left_q);
    by = (vy > 0) ? (W+1)'(top_q) : (W+1)'(bottom_q);
    offx = bx - (W+1)'(px);
    offy = by - (W+1)'(py);
    cmn_d.px     = px;
    cmn_d.py     = py;
    cmn_d.in_box = (px <= right_q) && (px >= left_q) && (py <= top_q) && (py >= bottom_q);
    cmn_d.vx_pos = vx > 0;
    cmn_d.vy_pos = vy > 0;
    prx_d.ok  = vx != '0;
    prx_d.neg = offx[W] ^ vy[W-1] ^ vx[W-1];
    prx_d.a   = offx[W] ? W'(-offx) : W'(offx);
    prx_d.b   = vy[W-1] ? W'(-vy) : W'(vy);
    prx_d.d   = vx[W-1] ? W'(-vx) : W'(vx);
    pry_d.ok  = vy != '0;
    pry_d.neg = offy[W] ^ vx[W-1] ^ vy[W-1];
    pry_d.a   = offy[W] ? W'(-offy) : W'(offy);
    pry_d.b   = prx_d.d;
    pry_d.d   = prx_d.b;
  end

  // Stage 3 setup: a quotient fits in W bits only when the high half is below d.
  always_comb begin
    dvx_d.ok  = mux_q.ok && (mux_q.prod[2*W-1:W] < mux_q.d);
    dvx_d.neg = mux_q.neg;
    dvx_d.rem = mux_q.prod[2*W-1:W];
    dvx_d.dq  = mux_q.prod[W-1:0];
    dvx_d.d   = mux_q.d;
    dvy_d.ok  = muy_q.ok && (muy_q.prod[2*W-1:W] < muy_q.d);
    dvy_d.neg = muy_q.neg;
    dvy_d.rem = muy_q.prod[2*W-1:W];
    dvy_d.dq  = muy_q.prod[W-1:0];
    dvy_d.d   = muy_q.d;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) req_q <= in_data_i;
    if (en[1]) begin
      cmn_q[1] <= cmn_d;
      prx_q    <= prx_d;
      pry_q    <= pry_d;
    end
    if (en[2]) begin
      mux_q <= '{ok: prx_q.ok, neg: prx_q.neg, prod: prx_q.a * prx_q.b, d: prx_q.d};
      muy_q <= '{ok: pry_q.ok, neg: pry_q.neg, prod: pry_q.a * pry_q.b, d: pry_q.d};
    end
    if (en[3]) begin
      dvx_q <= dvx_d;
      dvy_q <= dvy_d;
    end
    for (int k = 2; k < LAST; k++) begin
      if (en[k]) cmn_q[k] <= cmn_q[k-1];
    end
    if (en[LAST]) rsp_q <= rsp_d;
  end

  rre_div_lane u_div_x (
    .clk_i  (clk_i),
    .en_i   (en[4 +: W]),
    .init_i (dvx_q),
    .res_o  (resx)
  );

  rre_div_lane u_div_y (
    .clk_i  (clk_i),
    .en_i   (en[4 +: W]),
    .init_i (dvy_q),
    .res_o  (resy)
  );

  // Final stage: flag a start outside the box, else sign the quotients, add, check bounds, pick a hit (x border first).
  always_comb begin
    logic signed [W:0]   qx, qy;
    logic signed [W+1:0] cx, cy;
    logic                hitx, hity;
    cmn_t                c;
    c  = cmn_q[LAST-1];
    qx = resx.neg ? -$signed({1'b0, resx.dq}) : $signed({1'b0, resx.dq});
    qy = resy.neg ? -$signed({1'b0, resy.dq}) : $signed({1'b0, resy.dq});
    cx = (W+2)'($signed(c.py)) + (W+2)'(qx);
    cy = (W+2)'($signed(c.px)) + (W+2)'(qy);
    hitx = resx.ok && (cx <= (W+2)'(top_q)) && (cx >= (W+2)'(bottom_q));
    hity = resy.ok && (cy <= (W+2)'(right_q)) && (cy >= (W+2)'(left_q));
    rsp_d = '0;
    if (!c.in_box) begin
      rsp_d.exit_status = rre_pkg::ST_OUTSIDE;
    end else if (hitx) begin
      rsp_d.hit_x       = c.vx_pos ? right_q : left_q;
      rsp_d.hit_y       = cx[W-1:0];
      rsp_d.exit_status = rre_pkg::ST_EXIT;
    end else if (hity) begin
      rsp_d.hit_x       = cy[W-1:0];
      rsp_d.hit_y       = c.vy_pos ? top_q : bottom_q;
      rsp_d.exit_status = rre_pkg::ST_EXIT;
    end else begin
      rsp_d.exit_status = rre_pkg::ST_NO_EXIT;
    end
  end

  assign out_valid_o = valid_q[LAST];
  assign out_data_o  = rsp_q;

endmodule

@@ design/rre_checker.sv @@
`timescale 1ns / 1ps
module rre_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input rre_pkg::rsp_t out_data_o
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("response dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled response changed");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.exit_status == rre_pkg::ST_EXIT ||
                     out_data_o.exit_status == rre_pkg::ST_OUTSIDE ||
                     out_data_o.exit_status == rre_pkg::ST_NO_EXIT))
    else $error("bad status code");

  a_zero_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.exit_status != rre_pkg::ST_EXIT)
      |-> (out_data_o.hit_x == '0) && (out_data_o.hit_y == '0))
    else $error("nonzero point on a miss");

endmodule

bind ray_rectangle_exit_point rre_checker u_rre_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
